/* rtl/vha_pkg.sv */
// Shared constants for the velocity heading angle pipeline.
package vha_pkg;

    localparam int VEL_BITS_DEF = 20;   // default velocity component width
    localparam int FRAC_BITS    = 12;   // Q12 ratio fraction bits
    localparam int RATIO_BITS   = 13;   // ratio 0..4096
    localparam int ANGLE_BITS   = 20;   // signed output angle
    localparam int MAG_BITS     = 19;   // unsigned angle magnitude
    localparam int PROD_BITS    = 2 * RATIO_BITS;

    localparam logic [RATIO_BITS-1:0] RATIO_ONE  = 13'd4096;
    localparam logic [MAG_BITS-1:0]   DEG45_COEF = 19'd45;
    localparam logic [MAG_BITS-1:0]   DEG90_RAW  = 19'd368640;
    localparam logic [PROD_BITS:0]    CURVE_RND  = 27'd128;   // half of 256
    localparam int                    CURVE_SHIFT = 8;        // 16*4096 / 2^24 = 1/256

    localparam int ANGLE_MAX = 368640;

endpackage

/* rtl/velocity_heading_angle.sv */
// Velocity heading angle: pipelined polynomial atan2, Q12 ratio, degrees*4096 out.
//
//  channel | handshake          | payload                              | width
//  --------+--------------------+--------------------------------------+---------------
//  in      | i_valid / o_stall  | i_vel_x, i_vel_y (signed), i_face_left | VEL_BITS,1
//  out     | o_valid / i_stall  | o_angle (signed)                     | 20
//
//  One word per cycle while i_stall is low; the stages are one prep stage, one
//  restoring divide stage per ratio bit, a multiply stage and an output stage.
//  Each stage holds its word while the stage after it is full and not moving,
//  so bubbles close up and a stall loses or repeats nothing.
//  o_stall rises only once every stage holds a word and the output is stalled.
//  Reset (synchronous, active low) clears the valid bit of every stage only.
module velocity_heading_angle
    import vha_pkg::*;
#(
    parameter int VEL_BITS = VEL_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [VEL_BITS-1:0]   i_vel_x,
    input  logic signed [VEL_BITS-1:0]   i_vel_y,
    input  logic                         i_face_left,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [ANGLE_BITS-1:0] o_angle
);

    localparam int MW  = VEL_BITS;          // magnitude width, holds 2^(VEL_BITS-1)
    localparam int NW  = MW + FRAC_BITS;    // rounded dividend width
    localparam int QB  = RATIO_BITS;        // quotient bits = divide stages
    localparam int SD  = QB;                // index of last divide stage
    localparam int SM  = QB + 1;            // multiply stage
    localparam int SO  = QB + 2;            // output stage
    localparam int NS  = QB + 3;            // stage count

    // per-stage valid and advance
    logic          r_v   [0:NS-1];
    logic [NS:0]   w_rdy;

    // divider pipeline: partial remainder, remaining dividend bits, divisor, quotient
    logic [MW-1:0] r_rem  [0:SD];
    logic [QB-1:0] r_low  [0:SD];
    logic [MW-1:0] r_den  [0:SD];
    logic [QB-1:0] r_q    [0:SD];
    logic          r_steep[0:SM];
    logic          r_neg  [0:SM];

    logic [QB-1:0]        r_q_m;
    logic [PROD_BITS-1:0] r_prod;
    logic signed [ANGLE_BITS-1:0] r_angle;

    assign w_rdy[NS] = !i_stall;
    for (genvar k = 0; k < NS; k++) begin : g_rdy
        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];
    end

    assign o_stall = !w_rdy[0];
    assign o_valid = r_v[SO];
    assign o_angle = r_angle;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_v[k] <= 1'b0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // ---- stage 0: magnitudes, octant select, rounded dividend ----
    logic [MW-1:0] w_mx, w_my, w_ax, w_small, w_large;
    logic [NW-1:0] w_num;
    logic          w_steep;

    assign w_mx    = i_vel_x[MW-1] ? (~i_vel_x + 1'b1) : i_vel_x;
    assign w_my    = i_vel_y[MW-1] ? (~i_vel_y + 1'b1) : i_vel_y;
    assign w_ax    = (w_mx == '0) ? MW'(1) : w_mx;
    assign w_steep = w_my > w_ax;
    assign w_small = w_steep ? w_ax : w_my;
    assign w_large = w_steep ? w_my : w_ax;
    // small*4096 + large/2; the quotient by large stays below 2^13
    assign w_num   = {w_small, {FRAC_BITS{1'b0}}} + NW'(w_large[MW-1:1]);

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_rem[0]   <= {1'b0, w_num[NW-1:QB]};
            r_low[0]   <= w_num[QB-1:0];
            r_den[0]   <= w_large;
            r_q[0]     <= '0;
            r_steep[0] <= w_steep;
            r_neg[0]   <= i_vel_y[MW-1] ^ i_face_left;
        end
    end

    // ---- stages 1..13: one restoring divide step each ----
    for (genvar k = 1; k <= SD; k++) begin : g_div
        logic [MW:0]   w_t;
        logic [MW-1:0] w_d;
        logic          w_ge;

        assign w_t  = {r_rem[k-1], r_low[k-1][QB-1]};
        // difference is below the divisor whenever it is taken
        assign w_d  = w_t[MW-1:0] - r_den[k-1];
        assign w_ge = w_t >= {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (w_rdy[k]) begin
                r_rem[k]   <= w_ge ? w_d : w_t[MW-1:0];
                r_low[k]   <= {r_low[k-1][QB-2:0], 1'b0};
                r_den[k]   <= r_den[k-1];
                r_q[k]     <= {r_q[k-1][QB-2:0], w_ge};
                r_steep[k] <= r_steep[k-1];
                r_neg[k]   <= r_neg[k-1];
            end
        end
    end

    // ---- multiply stage: r*(4096-r) ----
    logic [QB-1:0] w_comp;
    assign w_comp = RATIO_ONE - r_q[SD];

    always_ff @(posedge i_clk) begin
        if (w_rdy[SM]) begin
            r_prod      <= r_q[SD] * w_comp;
            r_q_m       <= r_q[SD];
            r_steep[SM] <= r_steep[SD];
            r_neg[SM]   <= r_neg[SD];
        end
    end

    // ---- output stage: 45*r + round(prod/256), fold and sign ----
    logic [MAG_BITS-1:0]   w_lin, w_curve, w_atan, w_mag;
    logic [PROD_BITS:0]    w_cs;
    logic [ANGLE_BITS-1:0] w_mag_ext;

    assign w_lin     = MAG_BITS'(r_q_m) * DEG45_COEF;
    assign w_cs      = {1'b0, r_prod} + CURVE_RND;
    assign w_curve   = MAG_BITS'(w_cs >> CURVE_SHIFT);
    assign w_atan    = w_lin + w_curve;
    assign w_mag     = r_steep[SM] ? (DEG90_RAW - w_atan) : w_atan;
    assign w_mag_ext = {1'b0, w_mag};

    always_ff @(posedge i_clk) begin
        if (w_rdy[SO]) begin
            r_angle <= r_neg[SM] ? $signed(-w_mag_ext) : $signed(w_mag_ext);
        end
    end

    // ---- assertions ----
    // first partial remainder must be below the divisor
    a_rem_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] |-> (r_rem[0] < r_den[0]))
        else $error("initial remainder not below divisor");

    // ratio never exceeds one
    a_ratio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[SD] |-> (r_q[SD] <= RATIO_ONE))
        else $error("ratio above 4096");

    // angle stays within +-90 degrees
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_angle) <= ANGLE_MAX && $signed(o_angle) >= -ANGLE_MAX))
        else $error("angle out of range");

    // a word accepted at the input with the pipe free reaches stage 0
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v[0])
        else $error("accepted word lost at entry");

endmodule
